/* sv/multi_channel_moving_window_sum_core_macros.svh */
// Assertion macros shared by the checker file.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef MULTI_CHANNEL_MOVING_WINDOW_SUM_CORE_MACROS_SVH
`define MULTI_CHANNEL_MOVING_WINDOW_SUM_CORE_MACROS_SVH

// same-cycle implication
`define MCMWS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication
`define MCMWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

/* sv/mcmws_pkg.sv */
// Shared constants, widths and controller/datapath interface types.
// No dependencies.
package mcmws_pkg;

    localparam int NUM_CHANNELS = 32;
    localparam int MAX_WINDOW   = 256;

    localparam int CH_W    = 5;
    localparam int STAMP_W = 64;
    localparam int WIN_W   = 9;
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int POS_W   = $clog2(MAX_WINDOW);
    localparam int CHI_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DEPTH   = NUM_CHANNELS * MAX_WINDOW;
    localparam int ADDR_W  = $clog2(DEPTH);

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch input word
        logic clear;     // clear channel sum/count/position
        logic rd;        // read oldest sample
        logic sub;       // evict the sample just read
        logic wr;        // store new sample
        logic load;      // load result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_range;
        logic had;
        logic record;    // report yields a sample
        logic over;      // count above window - 1
        logic out_free;  // result register can take a word
    } sts_t;

endpackage

/* sv/mcmws_ctrl.sv */
// Sequencing state machine for the moving window sum core.
// Depends on mcmws_pkg.
module mcmws_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mcmws_pkg::sts_t    sts,
    output mcmws_pkg::cmd_t    cmd
);
    import mcmws_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_EV_RD  = 6'b000100,
        ST_EV_SUB = 6'b001000,
        ST_WRITE  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!sts.in_range || !sts.had)
                begin
                    state_next = ST_DONE;
                end
                else if (!sts.record)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_EV_RD;
                end
            end
            ST_EV_RD:
            begin
                if (sts.over)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_EV_SUB;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_EV_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = ST_EV_RD;
            end
            ST_WRITE:
            begin
                cmd.wr     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/mcmws_datapath.sv */
// Datapath: input latch, per-channel sum/count/position, sample ring memory,
// window clamp and result register. Depends on mcmws_pkg.
module mcmws_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mcmws_pkg::cmd_t                   cmd,
    output mcmws_pkg::sts_t                   sts,
    input  logic                              window_size_we,
    input  logic [mcmws_pkg::WIN_W-1:0]       window_size,
    input  logic [mcmws_pkg::CH_W-1:0]        channel,
    input  logic                              frame_had_queries,
    input  logic                              channel_used,
    input  logic [mcmws_pkg::STAMP_W-1:0]     begin_stamp,
    input  logic [mcmws_pkg::STAMP_W-1:0]     end_stamp,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mcmws_pkg::CH_W-1:0]        channel_out,
    output logic [mcmws_pkg::STAMP_W-1:0]     elapsed_ticks,
    output logic                              elapsed_valid,
    output logic [mcmws_pkg::STAMP_W-1:0]     window_total,
    output logic [mcmws_pkg::CNT_W-1:0]       window_count
);
    import mcmws_pkg::*;

    logic [CH_W-1:0]    ch_reg;
    logic               had_reg;
    logic               rec_reg;
    logic [STAMP_W-1:0] elapsed_reg;
    logic [WIN_W-1:0]   win_reg;

    logic [STAMP_W-1:0] sum_reg [NUM_CHANNELS];
    logic [CNT_W-1:0]   cnt_reg [NUM_CHANNELS];
    logic [POS_W-1:0]   pos_reg [NUM_CHANNELS];

    logic [STAMP_W-1:0] store_mem [DEPTH];
    logic [STAMP_W-1:0] rd_data_reg;

    logic               out_valid_reg;
    logic               out_valid_next;

    logic [CHI_W-1:0]   ch_idx;
    logic               in_range;
    logic [CNT_W-1:0]   keep;
    logic [STAMP_W-1:0] cur_sum;
    logic [CNT_W-1:0]   cur_cnt;
    logic [POS_W-1:0]   cur_pos;
    logic [POS_W-1:0]   oldest;
    logic [POS_W-1:0]   pos_inc;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;

    assign ch_idx   = ch_reg[CHI_W-1:0];
    assign in_range = (32'(ch_reg) < 32'(NUM_CHANNELS));
    assign cur_sum  = sum_reg[ch_idx];
    assign cur_cnt  = cnt_reg[ch_idx];
    assign cur_pos  = pos_reg[ch_idx];

    // window clamped to 1..MAX_WINDOW, minus one
    always_comb
    begin
        priority if (win_reg == '0)
        begin
            keep = '0;
        end
        else if (32'(win_reg) > 32'(MAX_WINDOW))
        begin
            keep = CNT_W'(MAX_WINDOW - 1);
        end
        else
        begin
            keep = CNT_W'(32'(win_reg) - 32'd1);
        end
    end

    always_comb
    begin
        if (32'(cur_pos) >= 32'(cur_cnt))
        begin
            oldest = POS_W'(32'(cur_pos) - 32'(cur_cnt));
        end
        else
        begin
            oldest = POS_W'(32'(cur_pos) + 32'(MAX_WINDOW) - 32'(cur_cnt));
        end
    end

    assign pos_inc = (cur_pos == POS_W'(MAX_WINDOW - 1)) ? '0 : cur_pos + POS_W'(1);
    assign rd_addr = ADDR_W'(32'(ch_idx) * 32'(MAX_WINDOW) + 32'(oldest));
    assign wr_addr = ADDR_W'(32'(ch_idx) * 32'(MAX_WINDOW) + 32'(cur_pos));

    assign sts.in_range = in_range;
    assign sts.had      = had_reg;
    assign sts.record   = rec_reg;
    assign sts.over     = (cur_cnt > keep);
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= WIN_W'(1);
        end
        else if (window_size_we)
        begin
            win_reg <= window_size;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg      <= channel;
            had_reg     <= frame_had_queries;
            rec_reg     <= channel_used && (begin_stamp != '0) && (end_stamp != '0);
            elapsed_reg <= end_stamp - begin_stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clear)
            begin
                sum_reg[ch_idx] <= '0;
                cnt_reg[ch_idx] <= '0;
                pos_reg[ch_idx] <= '0;
            end
            if (cmd.sub)
            begin
                sum_reg[ch_idx] <= cur_sum - rd_data_reg;
                cnt_reg[ch_idx] <= cur_cnt - CNT_W'(1);
            end
            if (cmd.wr)
            begin
                sum_reg[ch_idx] <= cur_sum + elapsed_reg;
                cnt_reg[ch_idx] <= cur_cnt + CNT_W'(1);
                pos_reg[ch_idx] <= pos_inc;
            end
        end
    end

    // sample ring, one port of each kind, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            store_mem[wr_addr] <= elapsed_reg;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            channel_out   <= ch_reg;
            elapsed_valid <= in_range && had_reg && rec_reg;
            elapsed_ticks <= (in_range && had_reg && rec_reg) ? elapsed_reg : '0;
            window_total  <= in_range ? cur_sum : '0;
            window_count  <= in_range ? cur_cnt : '0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* sv/multi_channel_moving_window_sum_core.sv */
// Per-channel moving window sum of timing samples.
// Input words on in_valid/in_ready carry a channel index, flags and two
// timestamps; one result word per input leaves on out_valid/out_ready.
// window_size_we/window_size write the window length, clamped to
// 1..MAX_WINDOW when used; write it only while no word is in flight.
// Sequence per input word: accept, check, then one of:
//   no sample recorded (no queries, clear, bad channel): result load
//   sample recorded: evict k samples (k is 1 in steady state), write, load
// Each eviction costs a registered read of the sample memory and a
// subtract; the memory has one read and one write port.
// The result is registered. The result register frees the input side:
// a new word is accepted while a result waits, and the block stalls only
// when its next result is ready before the old one is taken.
// Reset clears all channel sums, counts and ring positions at once and
// sets the window to 1; sample memory contents need no clearing.
// Depends on mcmws_pkg, mcmws_ctrl, mcmws_datapath.
module multi_channel_moving_window_sum_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              window_size_we,
    input  logic [mcmws_pkg::WIN_W-1:0]       window_size,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mcmws_pkg::CH_W-1:0]        channel,
    input  logic                              frame_had_queries,
    input  logic                              channel_used,
    input  logic [mcmws_pkg::STAMP_W-1:0]     begin_stamp,
    input  logic [mcmws_pkg::STAMP_W-1:0]     end_stamp,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mcmws_pkg::CH_W-1:0]        channel_out,
    output logic [mcmws_pkg::STAMP_W-1:0]     elapsed_ticks,
    output logic                              elapsed_valid,
    output logic [mcmws_pkg::STAMP_W-1:0]     window_total,
    output logic [mcmws_pkg::CNT_W-1:0]       window_count
);
    import mcmws_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mcmws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mcmws_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .window_size_we    (window_size_we),
        .window_size       (window_size),
        .channel           (channel),
        .frame_had_queries (frame_had_queries),
        .channel_used      (channel_used),
        .begin_stamp       (begin_stamp),
        .end_stamp         (end_stamp),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .channel_out       (channel_out),
        .elapsed_ticks     (elapsed_ticks),
        .elapsed_valid     (elapsed_valid),
        .window_total      (window_total),
        .window_count      (window_count)
    );

endmodule

/* sv/multi_channel_moving_window_sum_core_checker.sv */
// Port-level checker for the moving window sum core, plus its bind.
// Depends on mcmws_pkg and multi_channel_moving_window_sum_core_macros.svh.
`include "multi_channel_moving_window_sum_core_macros.svh"

module multi_channel_moving_window_sum_core_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              window_size_we,
    input  logic [mcmws_pkg::WIN_W-1:0]       window_size,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [mcmws_pkg::CH_W-1:0]        channel,
    input  logic                              frame_had_queries,
    input  logic                              channel_used,
    input  logic [mcmws_pkg::STAMP_W-1:0]     begin_stamp,
    input  logic [mcmws_pkg::STAMP_W-1:0]     end_stamp,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [mcmws_pkg::CH_W-1:0]        channel_out,
    input  logic [mcmws_pkg::STAMP_W-1:0]     elapsed_ticks,
    input  logic                              elapsed_valid,
    input  logic [mcmws_pkg::STAMP_W-1:0]     window_total,
    input  logic [mcmws_pkg::CNT_W-1:0]       window_count
);

    // a pending result word is not withdrawn
    `MCMWS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // one word in work at a time
    `MCMWS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    `MCMWS_ASSERT_NOW(a_invalid_zero, out_valid && !elapsed_valid, elapsed_ticks == '0)

    // a recorded sample leaves at least one sample in the window
    `MCMWS_ASSERT_NOW(a_rec_count, out_valid && elapsed_valid, window_count != '0)

    `MCMWS_ASSERT_NOW(a_empty_sum, out_valid && window_count == '0, window_total == '0)

endmodule

bind multi_channel_moving_window_sum_core multi_channel_moving_window_sum_core_checker u_checker (.*);
